>>> design/sem_pkg.sv
// shared types and constants for the rgb sobel edge block
`default_nettype none
package sem_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
	localparam logic [10:0] RESET_WIDTH  = 11'd640;
	localparam logic [12:0] RESET_HEIGHT = 13'd480;
	localparam logic [16:0] SUM_CLAMP = 17'd65280;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0]  red_edge;
		logic [7:0]  green_edge;
		logic [7:0]  blue_edge;
		logic [11:0] out_row;
		logic [9:0]  out_col;
		logic        last_of_run;
		logic        frame_done;
	} pix_out_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // capture input pixel, read line stores
		logic       shift;     // update window and write line stores
		logic       mag_start; // capture gradients for sel position
		logic       mag_sq;    // form sums of squares
		logic       mag_step;  // one root digit per channel
		logic       emit_load; // load result register
		logic       row_sel;   // 0: row r-1, 1: row r
		logic       col_sel;   // 0: col c-1, 1: col c
		logic       last;
		logic       advance;   // step input position
	} sem_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic row_ge1;
		logic row_last;
		logic col_ge1;
		logic col_last;
	} sem_stat_t;
endpackage
`default_nettype wire

>>> design/sem_ctrl.sv
// controller: sequences capture, window update and up to four results per pixel
`default_nettype none
module sem_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_busy,
	input  wire sem_pkg::sem_stat_t stat,
	output logic in_ready,
	output sem_pkg::sem_cmd_t cmd
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_SHFT = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	localparam logic [3:0] ROOT_STEPS = 4'd8;

	state_t state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic [3:0] cnt_q, cnt_d;
	logic       last_q, last_d;
	logic [1:0] nr, nc, ri, ci;
	logic       r_has_up;
	logic       c_has_left;

	assign r_has_up   = stat.row_ge1;
	assign c_has_left = stat.col_ge1;
	assign nr = {1'b0, r_has_up} + {1'b0, stat.row_last};
	assign nc = {1'b0, c_has_left} + {1'b0, stat.col_last};
	// result idx -> (row index a, col index b), a major
	assign ri = (nc == 2'd2) ? {1'b0, idx_q[1]} : idx_q;
	assign ci = (nc == 2'd2) ? {1'b0, idx_q[0]} : 2'd0;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		last_d  = last_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.shift = 1'b1;
				idx_d     = 2'd0;
				state_d   = ST_SHFT;
			end
			ST_SHFT: begin
				if (nr == 2'd0 || nc == 2'd0) begin
					cmd.advance = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.mag_start = 1'b1;
					cmd.row_sel   = !(r_has_up && ri == 2'd0);
					cmd.col_sel   = !(c_has_left && ci == 2'd0);
					cmd.last      = ({2'd0, idx_q} + 4'd1) == 4'(nr * nc);
					idx_d         = idx_q + 2'd1;
					last_d        = cmd.last;
					cnt_d         = 4'd0;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// squares, then one root digit a cycle, then the result load
				if (cnt_q == 4'd0) begin
					cmd.mag_sq = 1'b1;
					cnt_d      = cnt_q + 4'd1;
				end else if (cnt_q <= ROOT_STEPS) begin
					cmd.mag_step = 1'b1;
					cnt_d        = cnt_q + 4'd1;
				end else if (!out_busy) begin
					cmd.emit_load = 1'b1;
					if (last_q) begin
						cmd.advance = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						state_d = ST_SHFT;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 2'd0;
			cnt_q   <= 4'd0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
		end
	end
endmodule
`default_nettype wire

>>> design/sem_datapath.sv
// datapath: line stores, 3x3 window, position counters and magnitude unit
`default_nettype none
module sem_datapath #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire sem_pkg::pix_in_t in_pix,
	input  wire sem_pkg::sem_cmd_t cmd,
	input  wire logic out_take,
	output sem_pkg::sem_stat_t stat,
	output logic out_valid,
	output sem_pkg::pix_out_t out_pix
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [CW:0] w_eff;
	logic [RW:0] h_eff;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [23:0] up_mem [MAX_WIDTH];
	logic [23:0] lo_mem [MAX_WIDTH];
	logic [23:0] up_rd_q, lo_rd_q, pix_q;
	logic [23:0] win_q [3][3];
	logic signed [11:0] gx [3];
	logic signed [11:0] gy [3];
	logic [RW-1:0] orow;
	logic [CW-1:0] ocol;
	logic [RW:0]  rd;
	logic [CW:0]  cd;
	logic signed [11:0] gx_q [3];
	logic signed [11:0] gy_q [3];
	logic [15:0] s_q [3];
	logic [2:0]  sat_q;
	logic [8:0]  rem_q [3];
	logic [7:0]  root_q [3];
	logic [22:0] sum [3];
	logic [10:0] rem_sh [3];
	logic [10:0] trial [3];
	logic [7:0]  mag [3];
	logic [RW-1:0] orow_q;
	logic [CW-1:0] ocol_q;
	logic          last_q;
	logic          fdone_q;

	always_comb begin
		if (width_q == 11'd0) w_eff = (CW+1)'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(width_q);
		if (height_q == 13'd0) h_eff = (RW+1)'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
		else h_eff = (RW+1)'(height_q);
	end

	assign stat.row_ge1  = row_q != '0;
	assign stat.row_last = {1'b0, row_q} == h_eff - (RW+1)'(1);
	assign stat.col_ge1  = col_q != '0;
	assign stat.col_last = {1'b0, col_q} == w_eff - (CW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::RESET_WIDTH;
			height_q <= sem_pkg::RESET_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == sem_pkg::REG_WIDTH) width_q <= cfg_data[10:0];
			else height_q <= cfg_data;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.advance) begin
			if ({1'b0, col_q} + (CW+1)'(1) >= w_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + (RW+1)'(1) >= h_eff) row_q <= '0;
				else row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line stores: read on load, write on shift
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			up_rd_q <= up_mem[col_q];
			lo_rd_q <= lo_mem[col_q];
			pix_q   <= {in_pix.blue_in, in_pix.green_in, in_pix.red_in};
		end
		if (cmd.shift) begin
			up_mem[col_q] <= lo_rd_q;
			lo_mem[col_q] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++)
				for (int b = 0; b < 3; b++) win_q[a][b] <= '0;
		end else if (cmd.shift) begin
			for (int a = 0; a < 3; a++) begin
				win_q[a][0] <= win_q[a][1];
				win_q[a][1] <= win_q[a][2];
			end
			win_q[0][2] <= up_rd_q;
			win_q[1][2] <= lo_rd_q;
			win_q[2][2] <= pix_q;
		end
	end

	assign orow = cmd.row_sel ? row_q : row_q - RW'(1);
	assign ocol = cmd.col_sel ? col_q : col_q - CW'(1);
	// window index of output centre: 2 when output is the newest pixel, else 1
	assign rd = cmd.row_sel ? (RW+1)'(2) : (RW+1)'(1);
	assign cd = cmd.col_sel ? (CW+1)'(2) : (CW+1)'(1);

	always_comb begin
		logic [RW+1:0] rr;
		logic [CW+1:0] cc;
		logic [7:0]    v;
		logic          ok;
		logic [2:0]    wa, wb;
		logic [1:0]    ia, ib;
		for (int ch = 0; ch < 3; ch++) begin
			gx[ch] = '0;
			gy[ch] = '0;
		end
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				rr = {2'b0, orow} + (RW+2)'(dr);
				cc = {2'b0, ocol} + (CW+2)'(dc);
				wa = 3'(dr) + 3'(rd) - 3'd1;
				wb = 3'(dc) + 3'(cd) - 3'd1;
				ok = (rr != '0) && (rr <= {1'b0, h_eff}) &&
					(cc != '0) && (cc <= {1'b0, w_eff}) && (wa <= 3'd2) && (wb <= 3'd2);
				ia = (wa > 3'd2) ? 2'd2 : wa[1:0];
				ib = (wb > 3'd2) ? 2'd2 : wb[1:0];
				for (int ch = 0; ch < 3; ch++) begin
					v = ok ? win_q[ia][ib][8*ch +: 8] : 8'd0;
					gx[ch] = gx[ch] + 12'($signed({4'd0, v}) * (dc - 1) * ((dr == 1) ? 2 : 1));
					gy[ch] = gy[ch] + 12'($signed({4'd0, v}) * (dr - 1) * ((dc == 1) ? 2 : 1));
				end
			end
		end
	end

	// squares, digit-by-digit root with remainder, and rounding
	always_comb begin
		logic [21:0] sx, sy;
		for (int ch = 0; ch < 3; ch++) begin
			sx = 22'(gx_q[ch] * gx_q[ch]);
			sy = 22'(gy_q[ch] * gy_q[ch]);
			sum[ch]    = {1'b0, sx} + {1'b0, sy};
			rem_sh[ch] = {rem_q[ch], s_q[ch][15:14]};
			trial[ch]  = {1'b0, root_q[ch], 2'b01};
			// remainder above root means s > n*n+n
			if (sat_q[ch]) mag[ch] = 8'd255;
			else if (rem_q[ch] > {1'b0, root_q[ch]}) mag[ch] = root_q[ch] + 8'd1;
			else mag[ch] = root_q[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mag_start) begin
			for (int ch = 0; ch < 3; ch++) begin
				gx_q[ch] <= gx[ch];
				gy_q[ch] <= gy[ch];
			end
			orow_q  <= orow;
			ocol_q  <= ocol;
			last_q  <= cmd.last;
			fdone_q <= ({1'b0, orow} == h_eff - (RW+1)'(1)) &&
				({1'b0, ocol} == w_eff - (CW+1)'(1));
		end
		if (cmd.mag_sq) begin
			for (int ch = 0; ch < 3; ch++) begin
				s_q[ch]    <= sum[ch][15:0];
				sat_q[ch]  <= sum[ch] > {6'd0, sem_pkg::SUM_CLAMP};
				rem_q[ch]  <= 9'd0;
				root_q[ch] <= 8'd0;
			end
		end else if (cmd.mag_step) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (rem_sh[ch] >= trial[ch]) begin
					rem_q[ch]  <= 9'(rem_sh[ch] - trial[ch]);
					root_q[ch] <= {root_q[ch][6:0], 1'b1};
				end else begin
					rem_q[ch]  <= rem_sh[ch][8:0];
					root_q[ch] <= {root_q[ch][6:0], 1'b0};
				end
				s_q[ch] <= {s_q[ch][13:0], 2'b00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit_load) out_valid <= 1'b1;
		else if (out_take) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_pix.red_edge    <= mag[0];
			out_pix.green_edge  <= mag[1];
			out_pix.blue_edge   <= mag[2];
			out_pix.out_row     <= 12'(orow_q);
			out_pix.out_col     <= 10'(ocol_q);
			out_pix.last_of_run <= last_q;
			out_pix.frame_done  <= fdone_q;
		end
	end
endmodule
`default_nettype wire

>>> design/sobel_edge_magnitude_rgb.sv
// top level of the rgb sobel edge magnitude filter
//  channel | signals                                  | dir
//  in      | in_valid, in_ready, in_data              | pixel in
//  out     | out_valid, out_ready, out_data           | result out
//  cfg     | cfg_we, cfg_index, cfg_data              | register write
// a pixel passes capture and window update, then gives no result or 1..4 results
// a result: gradient capture, squaring, 8 root steps, then the output load
// the output load waits while the result register holds an untaken result
// reset clears control, counters and window; line stores are not cleared
// a register write restarts the frame at row 0, column 0
`default_nettype none
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire sem_pkg::pix_in_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output sem_pkg::pix_out_t out_data
);
	sem_pkg::sem_cmd_t  cmd;
	sem_pkg::sem_stat_t stat;
	logic in_fire, out_take, out_busy;

	assign in_fire  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;
	assign out_busy = out_valid && !out_ready;

	sem_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_busy, .stat, .in_ready, .cmd
	);

	sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_pix(in_data),
		.cmd, .out_take, .stat, .out_valid, .out_pix(out_data)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> !(out_valid && !out_ready)) else $error("result overwritten");
	a_load_then_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.shift) else $error("shift missing after load");
	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> !in_ready) else $error("ready during work");
endmodule
`default_nettype wire

>>> tb/sobel_edge_checker.sv
// checker for the rgb sobel edge filter: watches the channels, predicts and compares
`timescale 1ns / 1ps
module sobel_edge_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  sem_pkg::pix_in_t   in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  sem_pkg::pix_out_t  out_data,
	output int                 errors,
	output int                 pending
);
	localparam int MW = sem_pkg::DEF_MAX_WIDTH;
	localparam int MH = sem_pkg::DEF_MAX_HEIGHT;

	bit [10:0] width_reg;
	bit [12:0] height_reg;
	bit [23:0] upper_line [MW];
	bit [23:0] lower_line [MW];
	bit [23:0] win [3][3];
	int row_pos, col_pos;
	sem_pkg::pix_out_t expected_edges [$];

	assign pending = expected_edges.size();

	function automatic int eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > MW) return MW;
		return width_reg;
	endfunction

	function automatic int eff_h();
		if (height_reg == 0) return 1;
		if (height_reg > MH) return MH;
		return height_reg;
	endfunction

	function automatic bit [7:0] rounded_magnitude(int gx, int gy);
		int s, n, t;
		s = gx * gx + gy * gy;
		n = 0;
		if (s > 65280) return 8'd255;
		for (int b = 128; b != 0; b = b >> 1) begin
			t = n | b;
			if (t * t <= s) n = t;
		end
		if (s > n * n + n) n++;
		return n[7:0];
	endfunction

	// edge magnitudes of (i,k) from the window whose newest pixel is (r,c)
	function automatic bit [23:0] edge_at(int i, int k, int r, int c, int w, int h);
		int gx [3];
		int gy [3];
		int rr, cc, wa, wb, v;
		bit [23:0] res;
		for (int ch = 0; ch < 3; ch++) begin
			gx[ch] = 0;
			gy[ch] = 0;
		end
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				rr = i + dr;
				cc = k + dc;
				wa = rr - (r - 2);
				wb = cc - (c - 2);
				if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
				if (wa < 0 || wa > 2 || wb < 0 || wb > 2) continue;
				for (int ch = 0; ch < 3; ch++) begin
					v = win[wa][wb][8*ch +: 8];
					gx[ch] += v * dc * ((dr == 0) ? 2 : 1);
					gy[ch] += v * dr * ((dc == 0) ? 2 : 1);
				end
			end
		end
		for (int ch = 0; ch < 3; ch++)
			res[8*ch +: 8] = rounded_magnitude(gx[ch], gy[ch]);
		return res;
	endfunction

	task automatic take_pixel(sem_pkg::pix_in_t p);
		int w, h, r, c, nr, nc, n, total;
		int rows [2];
		int cols [2];
		bit [23:0] pix, up, lo, m;
		sem_pkg::pix_out_t e;
		w = eff_w();
		h = eff_h();
		r = row_pos;
		c = col_pos;
		nr = 0;
		nc = 0;
		n = 0;
		pix = {p.blue_in, p.green_in, p.red_in};
		if (r >= h) r = 0;
		if (c >= w) c = 0;
		up = upper_line[c];
		lo = lower_line[c];
		upper_line[c] = lo;
		lower_line[c] = pix;
		for (int a = 0; a < 3; a++) begin
			win[a][0] = win[a][1];
			win[a][1] = win[a][2];
		end
		win[0][2] = up;
		win[1][2] = lo;
		win[2][2] = pix;
		if (r >= 1) rows[nr++] = r - 1;
		if (r == h - 1) rows[nr++] = r;
		if (c >= 1) cols[nc++] = c - 1;
		if (c == w - 1) cols[nc++] = c;
		total = nr * nc;
		for (int a = 0; a < nr; a++) begin
			for (int b = 0; b < nc; b++) begin
				m = edge_at(rows[a], cols[b], r, c, w, h);
				e.red_edge    = m[7:0];
				e.green_edge  = m[15:8];
				e.blue_edge   = m[23:16];
				e.out_row     = rows[a][11:0];
				e.out_col     = cols[b][9:0];
				e.last_of_run = (n == total - 1);
				e.frame_done  = (rows[a] == h - 1 && cols[b] == w - 1);
				expected_edges.push_back(e);
				n++;
			end
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		row_pos = r;
		col_pos = c;
	endtask

	task automatic compare_edge(sem_pkg::pix_out_t got);
		sem_pkg::pix_out_t e;
		if (expected_edges.size() == 0) begin
			$display("%0t: unexpected result row %0d col %0d", $time, got.out_row, got.out_col);
			errors++;
			return;
		end
		e = expected_edges.pop_front();
		if (got.red_edge !== e.red_edge || got.green_edge !== e.green_edge ||
		    got.blue_edge !== e.blue_edge || got.out_row !== e.out_row ||
		    got.out_col !== e.out_col || got.last_of_run !== e.last_of_run ||
		    got.frame_done !== e.frame_done) begin
			$display("%0t: mismatch expected r=%0d g=%0d b=%0d row=%0d col=%0d last=%0d done=%0d",
				$time, e.red_edge, e.green_edge, e.blue_edge, e.out_row, e.out_col,
				e.last_of_run, e.frame_done);
			$display("%0t:          actual r=%0d g=%0d b=%0d row=%0d col=%0d last=%0d done=%0d",
				$time, got.red_edge, got.green_edge, got.blue_edge, got.out_row,
				got.out_col, got.last_of_run, got.frame_done);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  <= sem_pkg::RESET_WIDTH;
			height_reg <= sem_pkg::RESET_HEIGHT;
			row_pos = 0;
			col_pos = 0;
			for (int a = 0; a < 3; a++)
				for (int b = 0; b < 3; b++)
					win[a][b] = '0;
			expected_edges.delete();
		end else begin
			if (cfg_we) begin
				// any register write restarts the frame
				if (cfg_index == sem_pkg::REG_WIDTH) width_reg <= cfg_data[10:0];
				else height_reg <= cfg_data;
				row_pos = 0;
				col_pos = 0;
			end
			if (in_valid && in_ready) take_pixel(in_data);
			if (out_valid && out_ready) compare_edge(out_data);
		end
	end

	initial errors = 0;
endmodule

>>> tb/sobel_edge_magnitude_rgb_tb.sv
// testbench top for the rgb sobel edge filter: stimulus, stalls and verdict
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_tb;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sem_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sem_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	sem_pkg::pix_in_t in_data;
	logic out_valid;
	logic out_ready;
	sem_pkg::pix_out_t out_data;
	int errors;
	int pending;
	bit hold_req;
	int burst_left;
	int random_pixels;

	sobel_edge_magnitude_rgb dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	sobel_edge_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("sobel_edge_magnitude_rgb test failed");
		$finish;
	end

	// receiver: stall pattern changes at random, plus one long hold
	initial begin
		int mode;
		out_ready = 1'b0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req <= 1'b0;
			end else begin
				if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic sem_pkg::pix_in_t rand_pixel();
		sem_pkg::pix_in_t p;
		if ($urandom_range(0, 3) == 0) begin
			p.red_in   = $urandom_range(0, 1) ? 8'hff : 8'h00;
			p.green_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
			p.blue_in  = $urandom_range(0, 1) ? 8'hff : 8'h00;
		end else begin
			p = 24'($urandom);
		end
		return p;
	endfunction

	task automatic send_pixel(sem_pkg::pix_in_t p, bit gapless);
		int gap;
		if (!gapless && burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait for every expected result, then let any result-free pixel finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [sem_pkg::CFG_IDX_W-1:0] idx,
		logic [sem_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(int w, int h);
		write_reg(sem_pkg::REG_WIDTH, w[sem_pkg::CFG_DATA_W-1:0]);
		write_reg(sem_pkg::REG_HEIGHT, h[sem_pkg::CFG_DATA_W-1:0]);
	endtask

	task automatic send_random(int count, bit gapless);
		repeat (count) send_pixel(rand_pixel(), gapless);
	endtask

	initial begin
		sem_pkg::pix_in_t p;
		int w, h, cnt;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sem_pkg::REG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		hold_req = 1'b0;
		burst_left = 0;
		random_pixels = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset frame size: start of the first row
		send_random(20, 1'b0);
		drain();

		// 3x3 frames: checkerboard, row stripes and full scale channels, then zero to full scale
		set_frame(3, 3);
		for (int i = 0; i < 9; i++) begin
			p.red_in   = (i % 2) ? 8'hff : 8'h00;
			p.green_in = ((i / 3) % 2) ? 8'hff : 8'h00;
			p.blue_in  = 8'hff;
			send_pixel(p, 1'b0);
		end
		for (int i = 0; i < 9; i++) send_pixel((i < 4) ? 24'h000000 : 24'hffffff, 1'b1);
		drain();

		// single pixel frames, and zero sizes that act as one
		set_frame(1, 1);
		send_random(3, 1'b0);
		drain();
		set_frame(0, 0);
		send_random(2, 1'b0);
		drain();

		// widest and tallest frames, including values beyond the maximum
		set_frame(1024, 1);
		send_random(20, 1'b1);
		drain();
		set_frame(13'h1fff, 1);
		send_random(20, 1'b0);
		drain();
		set_frame(1, 13'h1fff);
		send_random(20, 1'b0);
		drain();
		set_frame(2, 4096);
		send_random(20, 1'b0);
		drain();

		// random small frames
		while (random_pixels < 90) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 6);
			case ($urandom_range(0, 3))
				0: write_reg(sem_pkg::REG_WIDTH, w[sem_pkg::CFG_DATA_W-1:0]);
				1: write_reg(sem_pkg::REG_HEIGHT, h[sem_pkg::CFG_DATA_W-1:0]);
				default: set_frame(w, h);
			endcase
			cnt = 10 + $urandom_range(0, 40);
			if (random_pixels == 0) hold_req <= 1'b1;
			send_random(cnt, $urandom_range(0, 3) == 0);
			random_pixels += cnt;
			drain();
		end

		if (errors == 0)
			$display("sobel_edge_magnitude_rgb test passed");
		else
			$display("sobel_edge_magnitude_rgb test failed");
		$finish;
	end
endmodule
